[design/link_frame_receiver_unit_defines.svh]
// ----------------------------------------------------------------------------
// Link frame receiver assertion macros
// Shared property shorthands for the receiver's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LINK_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define LINK_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lfr_pkg.sv]
// ----------------------------------------------------------------------------
// Link frame receiver package
// Types, codes and constants shared by the receiver modules.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_FLAG_BYTE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_ESCAPE_BYTE = 2'd1;
    localparam logic [IDX_W-1:0] CFG_STUFF_MASK  = 2'd2;
    localparam logic [IDX_W-1:0] CFG_MAX_RAW     = 2'd3;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] RST_FLAG_BYTE   = 8'h5C;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE = 8'h5D;
    localparam logic [BYTE_W-1:0] RST_STUFF_MASK  = 8'h20;
    localparam logic [LEN_W-1:0]  RST_MAX_RAW     = 16'd2053;

    // Valid address bytes.
    localparam logic [BYTE_W-1:0] ADDR_CMD = 8'h01;
    localparam logic [BYTE_W-1:0] ADDR_RSP = 8'h03;

    // Control codes: supervisory frames.
    localparam logic [BYTE_W-1:0] CTL_SET  = 8'h03;
    localparam logic [BYTE_W-1:0] CTL_DISC = 8'h0B;
    localparam logic [BYTE_W-1:0] CTL_UA   = 8'h07;
    localparam logic [BYTE_W-1:0] CTL_RR0  = 8'h01;
    localparam logic [BYTE_W-1:0] CTL_RR1  = 8'h21;
    localparam logic [BYTE_W-1:0] CTL_REJ0 = 8'h05;
    localparam logic [BYTE_W-1:0] CTL_REJ1 = 8'h25;
    // Control codes: data frames.
    localparam logic [BYTE_W-1:0] CTL_I0   = 8'h00;
    localparam logic [BYTE_W-1:0] CTL_I1   = 8'h02;

    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_FLAG = 3'd1,
        ST_ADDR = 3'd2,
        ST_CTRL = 3'd3,
        ST_BODY = 3'd4
    } t_state;

    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_SUPER   = 3'd1,
        KIND_GOOD    = 3'd2,
        KIND_CHECK   = 3'd3,
        KIND_ABORT   = 3'd4
    } t_kind;

    // One received byte held in the input stage.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_in_beat;

    // One result beat handed to the output stage.
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] control;
        logic [LEN_W-1:0]  length;
    } t_result;

    function automatic logic is_data(input logic [BYTE_W-1:0] c);
        return (c == CTL_I0) || (c == CTL_I1);
    endfunction

    function automatic logic is_control(input logic [BYTE_W-1:0] c);
        return (c == CTL_SET) || (c == CTL_DISC) || (c == CTL_UA) || (c == CTL_RR0) ||
               (c == CTL_RR1) || (c == CTL_REJ0) || (c == CTL_REJ1) || is_data(c);
    endfunction

endpackage

[design/lfr_in_stage.sv]
// ----------------------------------------------------------------------------
// Link frame receiver input stage
// Registers one received byte and holds it until the core consumes it.
// ----------------------------------------------------------------------------
`include "link_frame_receiver_unit_defines.svh"

module lfr_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [lfr_pkg::BYTE_W-1:0]  i_data,
    output logic                        o_stall,
    input  logic                        i_advance,
    output lfr_pkg::t_in_beat           o_beat
);

    logic                       r_valid;
    logic                       n_valid;
    logic [lfr_pkg::BYTE_W-1:0] r_data;
    logic                       accept;

    // The stage is free when empty or when the core takes its byte this cycle.
    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;

    // Checks.
    `LFR_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, r_valid,
        "input stage stalls while empty")
    `LFR_ASSERT_NOW(a_advance_needs_byte, i_clk, i_rst_n, i_advance, r_valid,
        "core advanced without a held byte")

endmodule

[design/lfr_core.sv]
// ----------------------------------------------------------------------------
// Link frame receiver core
// Frame state machine, header check, de-stuffing, hold-back and frame report.
// ----------------------------------------------------------------------------
`include "link_frame_receiver_unit_defines.svh"

module lfr_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lfr_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [lfr_pkg::CFG_W-1:0]   i_cfg_data,
    input  lfr_pkg::t_in_beat           i_beat,
    input  logic                        i_out_ready,
    output logic                        o_advance,
    output logic                        o_push,
    output lfr_pkg::t_result            o_result
);

    // Configuration registers.
    logic [lfr_pkg::BYTE_W-1:0] r_flag_byte;
    logic [lfr_pkg::BYTE_W-1:0] r_escape_byte;
    logic [lfr_pkg::BYTE_W-1:0] r_stuff_mask;
    logic [lfr_pkg::LEN_W-1:0]  r_max_raw;

    // Frame state.
    lfr_pkg::t_state            r_state,   n_state;
    logic [lfr_pkg::BYTE_W-1:0] r_addr,    n_addr;
    logic [lfr_pkg::BYTE_W-1:0] r_ctrl,    n_ctrl;
    logic                       r_escape,  n_escape;
    logic [lfr_pkg::BYTE_W-1:0] r_held,    n_held;
    logic                       r_held_ok, n_held_ok;
    logic [lfr_pkg::BYTE_W-1:0] r_xor,     n_xor;
    logic [lfr_pkg::LEN_W-1:0]  r_raw,     n_raw;
    logic [lfr_pkg::LEN_W-1:0]  r_emitted, n_emitted;

    logic                       res_valid;
    lfr_pkg::t_kind             res_kind;
    logic [lfr_pkg::BYTE_W-1:0] res_payload;
    logic [lfr_pkg::BYTE_W-1:0] b;
    logic [lfr_pkg::BYTE_W-1:0] x;
    logic                       have_x;

    // A byte moves on only when the output stage could take a result.
    assign o_advance = i_beat.valid && i_out_ready;
    assign b         = i_beat.data;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_byte   <= lfr_pkg::RST_FLAG_BYTE;
            r_escape_byte <= lfr_pkg::RST_ESCAPE_BYTE;
            r_stuff_mask  <= lfr_pkg::RST_STUFF_MASK;
            r_max_raw     <= lfr_pkg::RST_MAX_RAW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lfr_pkg::CFG_FLAG_BYTE:   r_flag_byte   <= i_cfg_data[lfr_pkg::BYTE_W-1:0];
                lfr_pkg::CFG_ESCAPE_BYTE: r_escape_byte <= i_cfg_data[lfr_pkg::BYTE_W-1:0];
                lfr_pkg::CFG_STUFF_MASK:  r_stuff_mask  <= i_cfg_data[lfr_pkg::BYTE_W-1:0];
                lfr_pkg::CFG_MAX_RAW:     r_max_raw     <= i_cfg_data[lfr_pkg::LEN_W-1:0];
            endcase
        end
    end

    // Next state and result for the byte at the head of the input stage.
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_ctrl      = r_ctrl;
        n_escape    = r_escape;
        n_held      = r_held;
        n_held_ok   = r_held_ok;
        n_xor       = r_xor;
        n_raw       = r_raw;
        n_emitted   = r_emitted;
        res_valid   = 1'b0;
        res_kind    = lfr_pkg::KIND_PAYLOAD;
        res_payload = '0;
        x           = b;
        have_x      = 1'b0;

        unique case (r_state)
            lfr_pkg::ST_FLAG: begin
                if (b == lfr_pkg::ADDR_CMD || b == lfr_pkg::ADDR_RSP) begin
                    n_addr  = b;
                    n_state = lfr_pkg::ST_ADDR;
                end else if (b != r_flag_byte) begin
                    n_state = lfr_pkg::ST_HUNT;
                end
            end
            lfr_pkg::ST_ADDR: begin
                priority if (b == r_flag_byte) begin
                    n_state = lfr_pkg::ST_FLAG;
                end else if (lfr_pkg::is_control(b)) begin
                    n_ctrl  = b;
                    n_state = lfr_pkg::ST_CTRL;
                end else begin
                    n_state = lfr_pkg::ST_HUNT;
                end
            end
            lfr_pkg::ST_CTRL: begin
                // Header check byte first; a flag here restarts the header.
                priority if (b == (r_addr ^ r_ctrl)) begin
                    n_state   = lfr_pkg::ST_BODY;
                    n_escape  = 1'b0;
                    n_held    = '0;
                    n_held_ok = 1'b0;
                    n_xor     = '0;
                    n_raw     = '0;
                    n_emitted = '0;
                end else if (b == r_flag_byte) begin
                    n_state = lfr_pkg::ST_FLAG;
                end else begin
                    n_state = lfr_pkg::ST_HUNT;
                end
            end
            lfr_pkg::ST_BODY: begin
                priority if (b == r_flag_byte) begin
                    // Closing flag: report the frame.
                    n_state   = lfr_pkg::ST_HUNT;
                    res_valid = 1'b1;
                    if (!lfr_pkg::is_data(r_ctrl)) begin
                        res_kind = (r_raw == '0) ? lfr_pkg::KIND_SUPER : lfr_pkg::KIND_CHECK;
                    end else if (!r_held_ok || r_escape || r_held != r_xor) begin
                        res_kind = lfr_pkg::KIND_CHECK;
                    end else begin
                        res_kind = lfr_pkg::KIND_GOOD;
                    end
                end else if (r_raw >= r_max_raw) begin
                    n_state   = lfr_pkg::ST_HUNT;
                    res_valid = 1'b1;
                    res_kind  = lfr_pkg::KIND_ABORT;
                end else begin
                    n_raw = r_raw + 16'd1;
                    priority if (r_escape) begin
                        n_escape = 1'b0;
                        x        = b ^ r_stuff_mask;
                        have_x   = 1'b1;
                    end else if (b == r_escape_byte) begin
                        n_escape = 1'b1;
                    end else begin
                        have_x = 1'b1;
                    end
                    // Data frames hold each byte back by one.
                    if (have_x && lfr_pkg::is_data(r_ctrl)) begin
                        n_held    = x;
                        n_held_ok = 1'b1;
                        if (r_held_ok) begin
                            n_xor       = r_xor ^ r_held;
                            n_emitted   = r_emitted + 16'd1;
                            res_valid   = 1'b1;
                            res_kind    = lfr_pkg::KIND_PAYLOAD;
                            res_payload = r_held;
                        end
                    end
                end
            end
            default: begin
                n_state = (b == r_flag_byte) ? lfr_pkg::ST_FLAG : lfr_pkg::ST_HUNT;
            end
        endcase
    end

    // Frame state registers, updated once per consumed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lfr_pkg::ST_HUNT;
            r_addr    <= '0;
            r_ctrl    <= '0;
            r_escape  <= 1'b0;
            r_held    <= '0;
            r_held_ok <= 1'b0;
            r_xor     <= '0;
            r_raw     <= '0;
            r_emitted <= '0;
        end else if (o_advance) begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_ctrl    <= n_ctrl;
            r_escape  <= n_escape;
            r_held    <= n_held;
            r_held_ok <= n_held_ok;
            r_xor     <= n_xor;
            r_raw     <= n_raw;
            r_emitted <= n_emitted;
        end
    end

    assign o_push           = o_advance && res_valid;
    assign o_result.kind    = res_kind;
    assign o_result.payload = res_payload;
    assign o_result.address = r_addr;
    assign o_result.control = r_ctrl;
    assign o_result.length  = n_emitted;

    // Checks.
    `LFR_ASSERT_NEXT(a_header_clears_frame, i_clk, i_rst_n,
        o_advance && r_state == lfr_pkg::ST_CTRL && b == (r_addr ^ r_ctrl),
        r_state == lfr_pkg::ST_BODY && r_raw == '0 && !r_held_ok && r_emitted == '0,
        "frame counters not cleared after a good header")
    `LFR_ASSERT_NOW(a_emitted_within_raw, i_clk, i_rst_n,
        r_state == lfr_pkg::ST_BODY, r_emitted <= r_raw,
        "more payload bytes emitted than raw bytes received")
    `LFR_ASSERT_NOW(a_payload_needs_held, i_clk, i_rst_n,
        o_push && o_result.kind == lfr_pkg::KIND_PAYLOAD,
        r_held_ok && r_state == lfr_pkg::ST_BODY,
        "payload beat without a held byte")

endmodule

[design/lfr_out_stage.sv]
// ----------------------------------------------------------------------------
// Link frame receiver output stage
// Result register that holds one beat until the receiver takes it.
// ----------------------------------------------------------------------------
`include "link_frame_receiver_unit_defines.svh"

module lfr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lfr_pkg::t_result  i_result,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output lfr_pkg::t_result  o_result
);

    logic             r_valid;
    logic             n_valid;
    lfr_pkg::t_result r_result;

    // Room for a new beat when empty or when the held beat leaves now.
    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        if (i_push) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Checks.
    `LFR_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, i_push, o_ready,
        "result pushed over a beat that is still waiting")

endmodule

[design/link_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// Link frame receiver unit
// Byte-stuffed frame receiver: flag hunt, header check, de-stuffing, report.
// ----------------------------------------------------------------------------
// The receiver takes one line byte per clock cycle for as long as the result
// side does not stall. Its result for a byte, if any, is registered: the
// byte is held in the input register while the core works on it, and the
// result is then written to the result register. The core computes the
// whole per-byte update of the frame state machine combinationally from the
// held byte. Payload bytes of a data frame come out one byte late, since the
// last de-stuffed byte before the closing flag is the frame's XOR check; the
// closing flag yields one frame report and an overlong body one abort
// report. Configuration registers may be written only while no byte is in
// flight.
// ----------------------------------------------------------------------------
module link_frame_receiver_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  logic [lfr_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [lfr_pkg::CFG_W-1:0]   i_cfg_data,
    // Received byte channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lfr_pkg::BYTE_W-1:0]  i_rx_byte,
    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_kind,
    output logic [lfr_pkg::BYTE_W-1:0]  o_payload,
    output logic [lfr_pkg::BYTE_W-1:0]  o_address,
    output logic [lfr_pkg::BYTE_W-1:0]  o_control,
    output logic [lfr_pkg::LEN_W-1:0]   o_length
);

    lfr_pkg::t_in_beat in_beat;
    lfr_pkg::t_result  core_result;
    lfr_pkg::t_result  out_result;
    logic              advance;
    logic              push;
    logic              out_ready;

    // Input register.
    lfr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_rx_byte),
        .o_stall   (o_in_stall),
        .i_advance (advance),
        .o_beat    (in_beat)
    );

    // Frame logic.
    lfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_beat      (in_beat),
        .i_out_ready (out_ready),
        .o_advance   (advance),
        .o_push      (push),
        .o_result    (core_result)
    );

    // Result register.
    lfr_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_kind    = out_result.kind;
    assign o_payload = out_result.payload;
    assign o_address = out_result.address;
    assign o_control = out_result.control;
    assign o_length  = out_result.length;

endmodule

[test/link_frame_receiver_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link frame receiver unit testbench
// Sends line bytes, predicts each report with its own copy of the frame
// receiver and checks every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module link_frame_receiver_unit_test;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int TIMEOUT_NS   = 4_000_000;

    typedef logic [lfr_pkg::BYTE_W-1:0] t_bytes [$];

    // Ways in which a generated frame departs from a well-formed one.
    typedef enum int {
        FD_NONE,
        FD_BAD_CHECK,
        FD_NO_CHECK,
        FD_TRAIL_ESC,
        FD_BAD_HDR,
        FD_EXTRA_FLAGS
    } t_defect;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [lfr_pkg::IDX_W-1:0]   i_cfg_index = '0;
    logic [lfr_pkg::CFG_W-1:0]   i_cfg_data  = '0;
    logic                        i_in_valid  = 1'b0;
    logic [lfr_pkg::BYTE_W-1:0]  i_rx_byte   = '0;
    logic                        i_out_stall = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [2:0]                  o_kind;
    logic [lfr_pkg::BYTE_W-1:0]  o_payload;
    logic [lfr_pkg::BYTE_W-1:0]  o_address;
    logic [lfr_pkg::BYTE_W-1:0]  o_control;
    logic [lfr_pkg::LEN_W-1:0]   o_length;

    // Receiver copy: configuration.
    logic [lfr_pkg::BYTE_W-1:0]  flag_cfg    = lfr_pkg::RST_FLAG_BYTE;
    logic [lfr_pkg::BYTE_W-1:0]  esc_cfg     = lfr_pkg::RST_ESCAPE_BYTE;
    logic [lfr_pkg::BYTE_W-1:0]  mask_cfg    = lfr_pkg::RST_STUFF_MASK;
    logic [lfr_pkg::LEN_W-1:0]   max_raw_cfg = lfr_pkg::RST_MAX_RAW;

    // Receiver copy: frame state.
    lfr_pkg::t_state             rx_state      = lfr_pkg::ST_HUNT;
    logic [lfr_pkg::BYTE_W-1:0]  frame_addr    = '0;
    logic [lfr_pkg::BYTE_W-1:0]  frame_ctrl    = '0;
    logic                        esc_armed     = 1'b0;
    logic [lfr_pkg::BYTE_W-1:0]  held_data     = '0;
    logic                        held_full     = 1'b0;
    logic [lfr_pkg::BYTE_W-1:0]  payload_xor   = '0;
    logic [lfr_pkg::LEN_W-1:0]   raw_bytes     = '0;
    logic [lfr_pkg::LEN_W-1:0]   payload_count = '0;

    lfr_pkg::t_result   expected_reports [$];
    int                 src_idle_pct   = 0;
    int                 sink_stall_pct = 0;
    int                 failures       = 0;
    int                 reports        = 0;

    link_frame_receiver_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_payload   (o_payload),
        .o_address   (o_address),
        .o_control   (o_control),
        .o_length    (o_length)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // The result side stalls at random, at a rate set per phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Frame receiver prediction
    // ------------------------------------------------------------------------

    function automatic logic [lfr_pkg::BYTE_W-1:0] ctrl_code(input int unsigned idx);
        case (idx)
            0: return lfr_pkg::CTL_SET;
            1: return lfr_pkg::CTL_DISC;
            2: return lfr_pkg::CTL_UA;
            3: return lfr_pkg::CTL_RR0;
            4: return lfr_pkg::CTL_RR1;
            5: return lfr_pkg::CTL_REJ0;
            6: return lfr_pkg::CTL_REJ1;
            7: return lfr_pkg::CTL_I0;
            default: return lfr_pkg::CTL_I1;
        endcase
    endfunction

    function automatic bit known_ctrl(input logic [lfr_pkg::BYTE_W-1:0] c);
        for (int i = 0; i < 9; i++) begin
            if (c == ctrl_code(i)) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit data_ctrl(input logic [lfr_pkg::BYTE_W-1:0] c);
        return (c == lfr_pkg::CTL_I0) || (c == lfr_pkg::CTL_I1);
    endfunction

    function automatic lfr_pkg::t_result report(input lfr_pkg::t_kind k,
                                                input logic [lfr_pkg::BYTE_W-1:0] p);
        lfr_pkg::t_result r;
        r.kind    = k;
        r.payload = p;
        r.address = frame_addr;
        r.control = frame_ctrl;
        r.length  = payload_count;
        return r;
    endfunction

    // Advances the receiver copy by one line byte; returns 1 with the report
    // when the byte causes one.
    function automatic bit frame_step(input logic [lfr_pkg::BYTE_W-1:0] b,
                                      output lfr_pkg::t_result r);
        logic [lfr_pkg::BYTE_W-1:0] x;
        r = '0;
        case (rx_state)
            lfr_pkg::ST_FLAG: begin
                if (b == lfr_pkg::ADDR_CMD || b == lfr_pkg::ADDR_RSP) begin
                    frame_addr = b;
                    rx_state   = lfr_pkg::ST_ADDR;
                end else if (b != flag_cfg) begin
                    rx_state = lfr_pkg::ST_HUNT;
                end
                return 1'b0;
            end
            lfr_pkg::ST_ADDR: begin
                if (b == flag_cfg) begin
                    rx_state = lfr_pkg::ST_FLAG;
                end else if (known_ctrl(b)) begin
                    frame_ctrl = b;
                    rx_state   = lfr_pkg::ST_CTRL;
                end else begin
                    rx_state = lfr_pkg::ST_HUNT;
                end
                return 1'b0;
            end
            lfr_pkg::ST_CTRL: begin
                // A good header check clears everything kept per frame.
                if (b == (frame_addr ^ frame_ctrl)) begin
                    rx_state      = lfr_pkg::ST_BODY;
                    esc_armed     = 1'b0;
                    held_data     = '0;
                    held_full     = 1'b0;
                    payload_xor   = '0;
                    raw_bytes     = '0;
                    payload_count = '0;
                end else if (b == flag_cfg) begin
                    rx_state = lfr_pkg::ST_FLAG;
                end else begin
                    rx_state = lfr_pkg::ST_HUNT;
                end
                return 1'b0;
            end
            lfr_pkg::ST_BODY: begin
                // The closing flag reports the whole frame.
                if (b == flag_cfg) begin
                    rx_state = lfr_pkg::ST_HUNT;
                    if (!data_ctrl(frame_ctrl)) begin
                        r = report((raw_bytes == 0) ? lfr_pkg::KIND_SUPER
                                                    : lfr_pkg::KIND_CHECK, '0);
                    end else if (!held_full || esc_armed || held_data != payload_xor) begin
                        r = report(lfr_pkg::KIND_CHECK, '0);
                    end else begin
                        r = report(lfr_pkg::KIND_GOOD, '0);
                    end
                    return 1'b1;
                end
                if (raw_bytes >= max_raw_cfg) begin
                    rx_state = lfr_pkg::ST_HUNT;
                    r = report(lfr_pkg::KIND_ABORT, '0);
                    return 1'b1;
                end
                raw_bytes = raw_bytes + 16'd1;
                if (esc_armed) begin
                    esc_armed = 1'b0;
                    x = b ^ mask_cfg;
                end else if (b == esc_cfg) begin
                    esc_armed = 1'b1;
                    return 1'b0;
                end else begin
                    x = b;
                end
                if (!data_ctrl(frame_ctrl)) return 1'b0;
                // Payload comes out one byte late; the last one is the check.
                if (held_full) begin
                    payload_xor   = payload_xor ^ held_data;
                    payload_count = payload_count + 16'd1;
                    r = report(lfr_pkg::KIND_PAYLOAD, held_data);
                    held_data = x;
                    return 1'b1;
                end
                held_data = x;
                held_full = 1'b1;
                return 1'b0;
            end
            default: begin
                rx_state = (b == flag_cfg) ? lfr_pkg::ST_FLAG : lfr_pkg::ST_HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Builds the line bytes of one frame under the current configuration.
    function automatic t_bytes build_frame(input logic [lfr_pkg::BYTE_W-1:0] addr,
                                           input logic [lfr_pkg::BYTE_W-1:0] ctrl,
                                           input t_bytes pay,
                                           input t_defect fd);
        t_bytes q;
        t_bytes body;
        logic [lfr_pkg::BYTE_W-1:0] hdr;
        logic [lfr_pkg::BYTE_W-1:0] chk;
        if (fd == FD_EXTRA_FLAGS) begin
            repeat ($urandom_range(1, 3)) q.push_back(flag_cfg);
        end
        q.push_back(flag_cfg);
        q.push_back(addr);
        q.push_back(ctrl);
        hdr = addr ^ ctrl;
        if (fd == FD_BAD_HDR) hdr = hdr ^ 8'($urandom_range(1, 255));
        q.push_back(hdr);
        chk  = '0;
        body = pay;
        foreach (pay[i]) chk = chk ^ pay[i];
        if (data_ctrl(ctrl) && fd != FD_NO_CHECK) begin
            if (fd == FD_BAD_CHECK) chk = chk ^ 8'($urandom_range(1, 255));
            body.push_back(chk);
        end
        // Stuff every byte that would read as a flag or an escape.
        foreach (body[i]) begin
            if (body[i] == flag_cfg || body[i] == esc_cfg) begin
                q.push_back(esc_cfg);
                q.push_back(body[i] ^ mask_cfg);
            end else begin
                q.push_back(body[i]);
            end
        end
        if (fd == FD_TRAIL_ESC) q.push_back(esc_cfg);
        q.push_back(flag_cfg);
        return q;
    endfunction

    // Sends one beat and updates the prediction once it has been taken.
    task automatic send_byte(input logic [lfr_pkg::BYTE_W-1:0] b);
        bit               taken;
        lfr_pkg::t_result r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        if (frame_step(b, r)) expected_reports.push_back(r);
    endtask

    task automatic send_bytes(input t_bytes q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    // Waits until every predicted report has arrived and the pipeline is empty.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lfr_pkg::IDX_W-1:0] idx,
                             input logic [lfr_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            lfr_pkg::CFG_FLAG_BYTE:   flag_cfg    = data[lfr_pkg::BYTE_W-1:0];
            lfr_pkg::CFG_ESCAPE_BYTE: esc_cfg     = data[lfr_pkg::BYTE_W-1:0];
            lfr_pkg::CFG_STUFF_MASK:  mask_cfg    = data[lfr_pkg::BYTE_W-1:0];
            default:                  max_raw_cfg = data;
        endcase
    endtask

    // Writes all four registers; the byte registers get random upper bits.
    task automatic set_config(input logic [lfr_pkg::BYTE_W-1:0] flag,
                              input logic [lfr_pkg::BYTE_W-1:0] esc,
                              input logic [lfr_pkg::BYTE_W-1:0] mask,
                              input logic [lfr_pkg::LEN_W-1:0]  max_raw);
        write_reg(lfr_pkg::CFG_FLAG_BYTE,   {8'($urandom), flag});
        write_reg(lfr_pkg::CFG_ESCAPE_BYTE, {8'($urandom), esc});
        write_reg(lfr_pkg::CFG_STUFF_MASK,  {8'($urandom), mask});
        write_reg(lfr_pkg::CFG_MAX_RAW,     max_raw);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, the rest line noise and
    // broken headers. Only frame and header bytes count toward the total.
    task automatic run_traffic(input int unsigned n_bytes);
        t_bytes                     q;
        t_bytes                     pay;
        int unsigned                sent;
        int unsigned                pick;
        int unsigned                len;
        logic [lfr_pkg::BYTE_W-1:0] addr;
        logic [lfr_pkg::BYTE_W-1:0] ctrl;
        t_defect                    fd;
        sent = 0;
        while (sent < n_bytes) begin
            q    = {};
            pay  = {};
            pick = $urandom_range(0, 99);
            if (pick < 76) begin
                addr = $urandom_range(0, 1) ? lfr_pkg::ADDR_RSP : lfr_pkg::ADDR_CMD;
                if ($urandom_range(0, 99) < 55) begin
                    ctrl = $urandom_range(0, 1) ? lfr_pkg::CTL_I1 : lfr_pkg::CTL_I0;
                end else begin
                    ctrl = ctrl_code($urandom_range(0, 8));
                end
                pick = $urandom_range(0, 99);
                if (!data_ctrl(ctrl)) len = (pick < 75) ? 0 : $urandom_range(1, 4);
                else if (pick < 80)   len = $urandom_range(0, 8);
                else if (pick < 95)   len = $urandom_range(9, 24);
                else                  len = $urandom_range(25, 60);
                repeat (len) begin
                    pick = $urandom_range(0, 99);
                    pay.push_back((pick < 12) ? flag_cfg :
                                  (pick < 24) ? esc_cfg : 8'($urandom));
                end
                pick = $urandom_range(0, 99);
                fd = (pick < 70) ? FD_NONE :
                     (pick < 78) ? FD_BAD_CHECK :
                     (pick < 84) ? FD_NO_CHECK :
                     (pick < 89) ? FD_TRAIL_ESC :
                     (pick < 94) ? FD_BAD_HDR : FD_EXTRA_FLAGS;
                q = build_frame(addr, ctrl, pay, fd);
                sent += q.size();
            end else if (pick < 88) begin
                // Line noise, with flags mixed in.
                repeat ($urandom_range(1, 6)) begin
                    q.push_back(($urandom_range(0, 99) < 30) ? flag_cfg : 8'($urandom));
                end
            end else begin
                // A flag followed by a broken run of header-like bytes.
                q.push_back(flag_cfg);
                repeat ($urandom_range(1, 5)) begin
                    case ($urandom_range(0, 3))
                        0: q.push_back(flag_cfg);
                        1: q.push_back($urandom_range(0, 1) ? lfr_pkg::ADDR_RSP
                                                            : lfr_pkg::ADDR_CMD);
                        2: q.push_back(ctrl_code($urandom_range(0, 8)));
                        default: q.push_back(8'($urandom));
                    endcase
                end
                sent += q.size();
            end
            send_bytes(q);
        end
    endtask

    task automatic run_phase(input logic [lfr_pkg::BYTE_W-1:0] flag,
                             input logic [lfr_pkg::BYTE_W-1:0] esc,
                             input logic [lfr_pkg::BYTE_W-1:0] mask,
                             input logic [lfr_pkg::LEN_W-1:0]  max_raw,
                             input int src_pct, input int sink_pct, input int unsigned n);
        drain();
        set_config(flag, esc, mask, max_raw);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        run_traffic(n);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Header handling and frame reports under the reset configuration.
    task automatic test_directed_frames();
        t_bytes pay;
        t_bytes q;
        // Supervisory frame with an empty body.
        q = build_frame(lfr_pkg::ADDR_CMD, lfr_pkg::CTL_SET, pay, FD_NONE);
        send_bytes(q);
        // Repeated opening flags; data frame with a stuffed flag and extreme values.
        pay = '{flag_cfg, 8'hFF, 8'h00};
        q = build_frame(lfr_pkg::ADDR_RSP, lfr_pkg::CTL_I0, pay, FD_EXTRA_FLAGS);
        send_bytes(q);
        // A flag where the control byte is due restarts the header; data frame
        // without check.
        pay = {};
        send_byte(flag_cfg);
        send_byte(lfr_pkg::ADDR_CMD);
        q = build_frame(lfr_pkg::ADDR_CMD, lfr_pkg::CTL_I1, pay, FD_NO_CHECK);
        send_bytes(q);
        // A bad address drops back to hunting; then an escape just before the close.
        send_byte(flag_cfg);
        send_byte(8'h04);
        q = build_frame(lfr_pkg::ADDR_CMD, lfr_pkg::CTL_I0, pay, FD_TRAIL_ESC);
        send_bytes(q);
    endtask

    // The smallest body limit: an overlong supervisory body aborts, while a
    // data frame that uses the limit exactly is still good.
    task automatic test_oversize_limit();
        t_bytes pay;
        t_bytes q;
        drain();
        set_config(flag_cfg, esc_cfg, mask_cfg, 16'd6);
        pay = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h40, 8'h80};
        q = build_frame(lfr_pkg::ADDR_RSP, lfr_pkg::CTL_UA, pay, FD_NONE);
        send_bytes(q);
        pay = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
        q = build_frame(lfr_pkg::ADDR_CMD, lfr_pkg::CTL_I1, pay, FD_NONE);
        send_bytes(q);
    endtask

    task automatic test_default_config();
        run_phase(lfr_pkg::RST_FLAG_BYTE, lfr_pkg::RST_ESCAPE_BYTE,
                  lfr_pkg::RST_STUFF_MASK, lfr_pkg::RST_MAX_RAW, 0, 0, 340);
    endtask

    task automatic test_shortest_limit();
        run_phase(8'h7E, 8'h7D, 8'h20, 16'd6, 68, 0, 340);
    endtask

    task automatic test_longest_limit();
        run_phase(8'h00, 8'hFF, 8'hFF, 16'hFFFF, 0, 68, 340);
    endtask

    task automatic test_zero_mask();
        run_phase(8'hFF, 8'h00, 8'h00, 16'd20, 16, 16, 340);
    endtask

    // Random registers, where flag and escape may collide with header codes.
    task automatic test_random_config();
        int src_pct;
        int sink_pct;
        repeat (2) begin
            case ($urandom_range(0, 3))
                0: begin src_pct = 0;  sink_pct = 0;  end
                1: begin src_pct = 68; sink_pct = 0;  end
                2: begin src_pct = 0;  sink_pct = 68; end
                default: begin src_pct = 16; sink_pct = 16; end
            endcase
            run_phase(8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom_range(6, 48)), src_pct, sink_pct, 170);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking: a beat seen here at the falling edge is taken at the
    // next rising edge.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        lfr_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display({"unexpected result: kind %0d payload %02h ",
                              "address %02h control %02h length %0d"},
                             o_kind, o_payload, o_address, o_control, o_length);
                end
            end else begin
                want = expected_reports.pop_front();
                if (o_kind != want.kind || o_payload != want.payload ||
                    o_address != want.address || o_control != want.control ||
                    o_length != want.length) begin
                    failures++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display({"mismatch: expected kind %0d payload %02h ",
                                  "address %02h control %02h length %0d"},
                                 want.kind, want.payload, want.address,
                                 want.control, want.length);
                        $display({"          got      kind %0d payload %02h ",
                                  "address %02h control %02h length %0d"},
                                 o_kind, o_payload, o_address, o_control, o_length);
                    end
                end
            end
        end
    end

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_oversize_limit();
        test_default_config();
        test_shortest_limit();
        test_longest_limit();
        test_zero_mask();
        test_random_config();
        drain();
        if (expected_reports.size() != 0) begin
            failures += expected_reports.size();
            $display("%0d expected results never arrived", expected_reports.size());
        end
        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
